/* hdl/svs_pkg.sv */
// Types and constants shared by the supply voltage supervisor.
package svs_pkg;

  // One input item: a sample tick or an external undervoltage event.
  typedef struct packed {
    logic       kind;
    logic [7:0] supply_sample;
  } sample_t;

  // One result item: flags after the step and request pulses.
  typedef struct packed {
    logic over_voltage;
    logic under_voltage;
    logic power_fail;
    logic was_operating;
    logic pause_request;
    logic control_reset_request;
    logic init_timer_clear;
  } result_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_VARIANT_MODE        = 3'd0,
    REG_OVER_THRESHOLD      = 3'd1,
    REG_OVER_HIGH_THRESHOLD = 3'd2,
    REG_START_THRESHOLD     = 3'd3,
    REG_STOP_THRESHOLD      = 3'd4,
    REG_VERY_LOW_THRESHOLD  = 3'd5,
    REG_SLEEP_THRESHOLD     = 3'd6,
    REG_OVER_TIME_LIMIT     = 3'd7
  } cfg_index_t;

  // Input item kinds.
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_EVENT = 1'b1;

  // Variant selection.
  localparam logic VARIANT_DEFAULT   = 1'b0;
  localparam logic VARIANT_ALTERNATE = 1'b1;

  // Fixed levels.
  localparam logic [7:0]  HOLD_BAND_LEVEL = 8'd214;
  localparam logic [7:0]  LOW_COUNT_MAX   = 8'd255;
  localparam logic [15:0] COUNT_MAX       = 16'hFFFF;

  // Register reset values.
  localparam logic        RST_VARIANT_MODE        = 1'b0;
  localparam logic [7:0]  RST_OVER_THRESHOLD      = 8'd201;
  localparam logic [7:0]  RST_OVER_HIGH_THRESHOLD = 8'd227;
  localparam logic [7:0]  RST_START_THRESHOLD     = 8'd113;
  localparam logic [7:0]  RST_STOP_THRESHOLD      = 8'd107;
  localparam logic [7:0]  RST_VERY_LOW_THRESHOLD  = 8'd63;
  localparam logic [7:0]  RST_SLEEP_THRESHOLD     = 8'd76;
  localparam logic [15:0] RST_OVER_TIME_LIMIT     = 16'd2000;

endpackage

/* hdl/supply_voltage_supervisor.sv */
// Supply voltage supervisor: band checks, overvoltage timing and request pulses.
// A result passes the input register, then the result register; the band logic
// between them is combinational. Throughput: one item per cycle while results
// are read, set by the single pass through the state update.
// A new item is taken while a finished result still waits in the result register.
// Reset (rst, synchronous, active high) clears all supervisor state and both
// valid flags, and loads the configuration registers with their default values.
module supply_voltage_supervisor (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    sample_valid,
  output logic                    sample_ready,
  input  svs_pkg::sample_t        sample,
  output logic                    result_valid,
  input  logic                    result_ready,
  output svs_pkg::result_t        result,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  svs_pkg::cfg_index_t     cfg_index,
  input  logic [15:0]             cfg_data
);
  import svs_pkg::*;

  // Configuration registers.
  logic        variant_mode;
  logic [7:0]  over_threshold;
  logic [7:0]  over_high_threshold;
  logic [7:0]  start_threshold;
  logic [7:0]  stop_threshold;
  logic [7:0]  very_low_threshold;
  logic [7:0]  sleep_threshold;
  logic [15:0] over_time_limit;

  // Supervisor state.
  logic [15:0] over_count, over_count_next;
  logic [7:0]  low_count, low_count_next;
  logic        sleep_entered, sleep_entered_next;
  logic        over_flag, over_flag_next;
  logic        under_flag, under_flag_next;
  logic        fail_flag, fail_flag_next;
  logic        operating_seen, operating_seen_next;

  // Pipeline registers.
  logic        in_full;
  sample_t     in_item;
  result_t     result_next;
  logic        advance;

  logic        pause, ctl_reset, timer_clear;
  logic [16:0] count_sum;
  logic [15:0] count_step;
  logic        over_expired;
  logic [7:0]  v;

  // Configuration writes are taken at once.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      variant_mode        <= RST_VARIANT_MODE;
      over_threshold      <= RST_OVER_THRESHOLD;
      over_high_threshold <= RST_OVER_HIGH_THRESHOLD;
      start_threshold     <= RST_START_THRESHOLD;
      stop_threshold      <= RST_STOP_THRESHOLD;
      very_low_threshold  <= RST_VERY_LOW_THRESHOLD;
      sleep_threshold     <= RST_SLEEP_THRESHOLD;
      over_time_limit     <= RST_OVER_TIME_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_VARIANT_MODE:        variant_mode        <= cfg_data[0];
        REG_OVER_THRESHOLD:      over_threshold      <= cfg_data[7:0];
        REG_OVER_HIGH_THRESHOLD: over_high_threshold <= cfg_data[7:0];
        REG_START_THRESHOLD:     start_threshold     <= cfg_data[7:0];
        REG_STOP_THRESHOLD:      stop_threshold      <= cfg_data[7:0];
        REG_VERY_LOW_THRESHOLD:  very_low_threshold  <= cfg_data[7:0];
        REG_SLEEP_THRESHOLD:     sleep_threshold     <= cfg_data[7:0];
        REG_OVER_TIME_LIMIT:     over_time_limit     <= cfg_data;
        default: ;
      endcase
    end
  end

  // The held item moves on when the result register is empty or being read.
  assign advance      = in_full && (!result_valid || result_ready);
  assign sample_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (sample_ready) begin
      in_full <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      in_item <= sample;
    end
  end

  // Saturating overvoltage count step.
  assign v            = in_item.supply_sample;
  assign over_expired = over_count > over_time_limit;
  assign count_step   = (variant_mode == VARIANT_DEFAULT && v > over_high_threshold)
                        ? 16'd2 : 16'd1;
  assign count_sum    = {1'b0, over_count} + {1'b0, count_step};

  // Next state and result for the held item.
  always_comb begin
    over_count_next     = over_count;
    low_count_next      = low_count;
    sleep_entered_next  = sleep_entered;
    over_flag_next      = over_flag;
    under_flag_next     = under_flag;
    fail_flag_next      = fail_flag;
    operating_seen_next = operating_seen;
    pause               = 1'b0;
    ctl_reset           = 1'b0;
    timer_clear         = 1'b0;

    if (in_item.kind == KIND_EVENT) begin
      under_flag_next = 1'b1;
      fail_flag_next  = 1'b0;
      timer_clear     = 1'b1;
      pause           = low_count < LOW_COUNT_MAX;
    end else if ((variant_mode == VARIANT_DEFAULT && v > over_threshold) ||
                 (variant_mode == VARIANT_ALTERNATE && v > over_high_threshold)) begin
      // Overvoltage region.
      if (over_expired) begin
        over_flag_next = 1'b1;
        pause          = 1'b1;
      end else begin
        over_count_next = count_sum[16] ? COUNT_MAX : count_sum[15:0];
      end
      sleep_entered_next = 1'b0;
      under_flag_next    = 1'b0;
      fail_flag_next     = 1'b0;
      low_count_next     = '0;
    end else if (variant_mode == VARIANT_ALTERNATE && v >= HOLD_BAND_LEVEL) begin
      // Hold band of the alternate variant.
      if (over_expired) begin
        pause = 1'b1;
      end else begin
        sleep_entered_next = 1'b0;
        under_flag_next    = 1'b0;
        fail_flag_next     = 1'b0;
        low_count_next     = '0;
      end
    end else begin
      // Voltage bands below the overvoltage region.
      over_count_next = '0;
      over_flag_next  = 1'b0;
      if (v >= start_threshold) begin
        operating_seen_next = 1'b1;
        sleep_entered_next  = 1'b0;
        under_flag_next     = 1'b0;
        fail_flag_next      = 1'b0;
        low_count_next      = '0;
      end else if (v >= stop_threshold) begin
        low_count_next     = '0;
        fail_flag_next     = 1'b0;
        sleep_entered_next = 1'b0;
      end else begin
        under_flag_next = 1'b1;
        fail_flag_next  = 1'b0;
        if (v < very_low_threshold) begin
          if (low_count < LOW_COUNT_MAX) begin
            low_count_next = low_count + 8'd1;
          end else begin
            under_flag_next = 1'b0;
          end
        end else begin
          low_count_next = '0;
        end
        if (low_count_next < LOW_COUNT_MAX) begin
          pause = 1'b1;
          if (v < sleep_threshold && operating_seen) begin
            fail_flag_next = 1'b1;
            if (!sleep_entered) begin
              sleep_entered_next = 1'b1;
              ctl_reset          = 1'b1;
            end
          end
        end
      end
    end

    result_next.over_voltage          = over_flag_next;
    result_next.under_voltage         = under_flag_next;
    result_next.power_fail            = fail_flag_next;
    result_next.was_operating         = operating_seen_next;
    result_next.pause_request         = pause;
    result_next.control_reset_request = ctl_reset;
    result_next.init_timer_clear      = timer_clear;
  end

  // State update, once per processed item.
  always_ff @(posedge clk) begin
    if (rst) begin
      over_count     <= '0;
      low_count      <= '0;
      sleep_entered  <= 1'b0;
      over_flag      <= 1'b0;
      under_flag     <= 1'b0;
      fail_flag      <= 1'b0;
      operating_seen <= 1'b0;
    end else if (advance) begin
      over_count     <= over_count_next;
      low_count      <= low_count_next;
      sleep_entered  <= sleep_entered_next;
      over_flag      <= over_flag_next;
      under_flag     <= under_flag_next;
      fail_flag      <= fail_flag_next;
      operating_seen <= operating_seen_next;
    end
  end

  // Result register; it holds until its transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

endmodule

/* tb/tb_supply_voltage_supervisor.sv */
// Self-checking testbench for the supply voltage supervisor, with a behavioural predictor.
module tb_supply_voltage_supervisor;
  import svs_pkg::*;

  // Kinds of sample run used by the random traffic generator.
  typedef enum int {
    SEG_OVER,
    SEG_HOLD,
    SEG_LOW,
    SEG_SLEEP,
    SEG_HYST,
    SEG_OPERATE,
    SEG_EVENT,
    SEG_NOISE
  } run_kind_t;

  logic        clk;
  logic        rst;
  logic        sample_valid;
  logic        sample_ready;
  sample_t     sample_bus;
  logic        result_valid;
  logic        result_ready;
  result_t     result_bus;
  logic        cfg_valid;
  logic        cfg_ready;
  cfg_index_t  cfg_index;
  logic [15:0] cfg_data;

  // Predictor copy of the configuration registers.
  logic        cfg_variant;
  logic [7:0]  cfg_over_thr;
  logic [7:0]  cfg_over_high_thr;
  logic [7:0]  cfg_start_thr;
  logic [7:0]  cfg_stop_thr;
  logic [7:0]  cfg_very_low_thr;
  logic [7:0]  cfg_sleep_thr;
  logic [15:0] cfg_over_limit;

  // Predictor copy of the supervisor state.
  logic [15:0] ov_timer;
  logic [7:0]  low_run;
  logic        sleep_latched;
  logic        ov_flag;
  logic        uv_flag;
  logic        pf_flag;
  logic        seen_operating;

  result_t pending_results [$];
  result_t want_result;
  int      mismatch_count = 0;
  int      items_sent = 0;
  int      results_checked = 0;
  int      reg_writes = 0;
  int      send_idle_pct;
  int      recv_idle_pct;
  string   field_names [7] = '{"over_voltage", "under_voltage", "power_fail",
                               "was_operating", "pause_request",
                               "control_reset_request", "init_timer_clear"};

  supply_voltage_supervisor DUT (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample_bus),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result_bus),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit, far beyond the slowest legal run.
  initial begin
    #5000000;
    $display("Timeout at %0t with %0d results still outstanding", $time,
             pending_results.size());
    $display("TB_ERROR");
    $finish;
  end

  // Receiver back-pressure, changed on the falling edge.
  always @(negedge clk) begin
    result_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each result transfer with the oldest expectation, field by field.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no expectation waiting, expected none, actual %b",
                 $time, result_bus);
        mismatch_count++;
      end else begin
        want_result = pending_results.pop_front();
        results_checked++;
        for (int i = 6; i >= 0; i--) begin
          if (want_result[i] !== result_bus[i]) begin
            $display("%0t: %s mismatch, expected %b, actual %b", $time,
                     field_names[6 - i], want_result[i], result_bus[i]);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Put the predictor into its post-reset state.
  task automatic reset_model();
    cfg_variant       = RST_VARIANT_MODE;
    cfg_over_thr      = RST_OVER_THRESHOLD;
    cfg_over_high_thr = RST_OVER_HIGH_THRESHOLD;
    cfg_start_thr     = RST_START_THRESHOLD;
    cfg_stop_thr      = RST_STOP_THRESHOLD;
    cfg_very_low_thr  = RST_VERY_LOW_THRESHOLD;
    cfg_sleep_thr     = RST_SLEEP_THRESHOLD;
    cfg_over_limit    = RST_OVER_TIME_LIMIT;
    ov_timer          = '0;
    low_run           = '0;
    sleep_latched     = 1'b0;
    ov_flag           = 1'b0;
    uv_flag           = 1'b0;
    pf_flag           = 1'b0;
    seen_operating    = 1'b0;
  endtask

  // Supply back in a healthy band: drop every undervoltage indication.
  task automatic clear_supply_status();
    sleep_latched = 1'b0;
    uv_flag       = 1'b0;
    pf_flag       = 1'b0;
    low_run       = '0;
  endtask

  // Supply inside the overvoltage region: time it, and trip once over the limit.
  task automatic time_over_voltage(input int step, inout logic pause);
    logic [16:0] sum;
    if (ov_timer > cfg_over_limit) begin
      ov_flag = 1'b1;
      pause   = 1'b1;
    end else begin
      sum      = {1'b0, ov_timer} + 17'(step);
      ov_timer = (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[15:0];
    end
    clear_supply_status();
  endtask

  // Voltage bands below the overvoltage region.
  task automatic apply_voltage_bands(input logic [7:0] v, inout logic pause,
                                     inout logic ctl_reset);
    ov_timer = '0;
    ov_flag  = 1'b0;
    if (v >= cfg_start_thr) begin
      seen_operating = 1'b1;
      clear_supply_status();
    end else if (v >= cfg_stop_thr) begin
      low_run       = '0;
      pf_flag       = 1'b0;
      sleep_latched = 1'b0;
    end else begin
      uv_flag = 1'b1;
      pf_flag = 1'b0;
      if (v < cfg_very_low_thr) begin
        if (low_run < LOW_COUNT_MAX) low_run = low_run + 8'd1;
        else uv_flag = 1'b0;
      end else begin
        low_run = '0;
      end
      if (low_run < LOW_COUNT_MAX) begin
        pause = 1'b1;
        if (v < cfg_sleep_thr && seen_operating) begin
          pf_flag = 1'b1;
          if (!sleep_latched) begin
            sleep_latched = 1'b1;
            ctl_reset     = 1'b1;
          end
        end
      end
    end
  endtask

  // Advance the predictor by one input item and work out its result.
  task automatic predict_supervisor_step(input sample_t item, output result_t res);
    logic       pause;
    logic       ctl_reset;
    logic       timer_clear;
    logic [7:0] v;
    pause       = 1'b0;
    ctl_reset   = 1'b0;
    timer_clear = 1'b0;
    v           = item.supply_sample;
    if (item.kind == KIND_EVENT) begin
      uv_flag     = 1'b1;
      pf_flag     = 1'b0;
      timer_clear = 1'b1;
      if (low_run < LOW_COUNT_MAX) pause = 1'b1;
    end else if (cfg_variant == VARIANT_DEFAULT) begin
      if (v > cfg_over_thr) time_over_voltage((v > cfg_over_high_thr) ? 2 : 1, pause);
      else apply_voltage_bands(v, pause, ctl_reset);
    end else begin
      if (v > cfg_over_high_thr) begin
        time_over_voltage(1, pause);
      end else if (v >= HOLD_BAND_LEVEL) begin
        if (ov_timer > cfg_over_limit) pause = 1'b1;
        else clear_supply_status();
      end else begin
        apply_voltage_bands(v, pause, ctl_reset);
      end
    end
    res.over_voltage          = ov_flag;
    res.under_voltage         = uv_flag;
    res.power_fail            = pf_flag;
    res.was_operating         = seen_operating;
    res.pause_request         = pause;
    res.control_reset_request = ctl_reset;
    res.init_timer_clear      = timer_clear;
  endtask

  // Offer one item, with random sender gaps, and record its expectation on transfer.
  task automatic send_item(input logic kind, input logic [7:0] value);
    sample_t item;
    result_t want;
    item.kind          = kind;
    item.supply_sample = value;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample_bus   <= item;
    do @(posedge clk); while (!sample_ready);
    predict_supervisor_step(item, want);
    pending_results.push_back(want);
    items_sent++;
  endtask

  // Random value within [lo, hi], clipped to the sample range.
  function automatic int rand_between(input int lo, input int hi);
    int a;
    int b;
    a = (lo < 0) ? 0 : (lo > 255) ? 255 : lo;
    b = (hi < 0) ? 0 : (hi > 255) ? 255 : hi;
    if (b < a) return a;
    return $urandom_range(b, a);
  endfunction

  // A run of items of one kind with samples drawn from one band.
  task automatic send_run(input logic kind, input int lo, input int hi, input int len);
    for (int i = 0; i < len; i++) send_item(kind, 8'(rand_between(lo, hi)));
  endtask

  // Stop offering items and wait until every outstanding result has arrived.
  task automatic drain_results();
    @(negedge clk);
    sample_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write all eight registers while the block is idle.
  task automatic load_settings(input logic [15:0] variant, input logic [15:0] over_thr,
                               input logic [15:0] over_high_thr,
                               input logic [15:0] start_thr, input logic [15:0] stop_thr,
                               input logic [15:0] very_low_thr,
                               input logic [15:0] sleep_thr, input logic [15:0] limit);
    logic [15:0] vals [8];
    cfg_index_t  idx;
    vals = '{variant, over_thr, over_high_thr, start_thr, stop_thr, very_low_thr,
             sleep_thr, limit};
    drain_results();
    for (int i = 0; i < 8; i++) begin
      idx = cfg_index_t'(i);
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      case (idx)
        REG_VARIANT_MODE:        cfg_variant       = vals[i][0];
        REG_OVER_THRESHOLD:      cfg_over_thr      = vals[i][7:0];
        REG_OVER_HIGH_THRESHOLD: cfg_over_high_thr = vals[i][7:0];
        REG_START_THRESHOLD:     cfg_start_thr     = vals[i][7:0];
        REG_STOP_THRESHOLD:      cfg_stop_thr      = vals[i][7:0];
        REG_VERY_LOW_THRESHOLD:  cfg_very_low_thr  = vals[i][7:0];
        REG_SLEEP_THRESHOLD:     cfg_sleep_thr     = vals[i][7:0];
        REG_OVER_TIME_LIMIT:     cfg_over_limit    = vals[i];
        default: ;
      endcase
      reg_writes++;
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // Reset configuration: every band edge, power fail entry and the external event.
  task automatic test_reset_defaults();
    send_item(KIND_TICK, 8'd0);
    send_item(KIND_TICK, 8'd113);
    send_item(KIND_TICK, 8'd75);
    send_item(KIND_TICK, 8'd75);
    send_item(KIND_TICK, 8'd62);
    send_item(KIND_TICK, 8'd76);
    send_item(KIND_TICK, 8'd106);
    send_item(KIND_TICK, 8'd112);
    send_item(KIND_TICK, 8'd202);
    send_item(KIND_TICK, 8'd228);
    send_item(KIND_EVENT, 8'hFF);
    send_item(KIND_TICK, 8'd255);
  endtask

  // Default variant with a short limit: double counting and the overvoltage trip.
  task automatic test_over_voltage_trip();
    load_settings(16'(VARIANT_DEFAULT), 16'(RST_OVER_THRESHOLD),
                  16'(RST_OVER_HIGH_THRESHOLD), 16'(RST_START_THRESHOLD),
                  16'(RST_STOP_THRESHOLD), 16'(RST_VERY_LOW_THRESHOLD),
                  16'(RST_SLEEP_THRESHOLD), 16'd1);
    send_item(KIND_TICK, 8'd228);
    send_item(KIND_TICK, 8'd202);
    send_item(KIND_TICK, 8'd228);
    send_item(KIND_TICK, 8'd201);
    send_item(KIND_TICK, 8'd202);
  endtask

  // Alternate variant: trip above the high level, then the fixed hold band.
  task automatic test_alternate_hold_band();
    load_settings(16'(VARIANT_ALTERNATE), 16'(RST_OVER_THRESHOLD),
                  16'(RST_OVER_HIGH_THRESHOLD), 16'(RST_START_THRESHOLD),
                  16'(RST_STOP_THRESHOLD), 16'(RST_VERY_LOW_THRESHOLD),
                  16'(RST_SLEEP_THRESHOLD), 16'd2);
    send_run(KIND_TICK, 228, 228, 4);
    send_item(KIND_TICK, 8'd214);
    send_item(KIND_TICK, 8'd227);
    send_item(KIND_TICK, 8'd213);
    send_item(KIND_TICK, 8'd214);
    send_item(KIND_TICK, 8'd220);
  endtask

  // Every threshold at both ends of its range, and both a short and a long overvoltage limit.
  task automatic test_threshold_extremes();
    load_settings(16'(VARIANT_DEFAULT), 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1);
    send_item(KIND_TICK, 8'd0);
    send_item(KIND_TICK, 8'd5);
    send_item(KIND_TICK, 8'd5);
    send_item(KIND_EVENT, 8'h00);
    load_settings(16'(VARIANT_ALTERNATE), 16'd255, 16'd255, 16'd255, 16'd255, 16'd255,
                  16'd255, 16'd65533);
    send_item(KIND_TICK, 8'd255);
    send_item(KIND_TICK, 8'd0);
    send_item(KIND_TICK, 8'd213);
  endtask

  // A long very-low run drives the low counter into saturation and back out.
  task automatic test_low_count_saturation(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    load_settings(16'(RST_VARIANT_MODE), 16'(RST_OVER_THRESHOLD),
                  16'(RST_OVER_HIGH_THRESHOLD), 16'(RST_START_THRESHOLD),
                  16'(RST_STOP_THRESHOLD), 16'(RST_VERY_LOW_THRESHOLD),
                  16'(RST_SLEEP_THRESHOLD), RST_OVER_TIME_LIMIT);
    send_item(KIND_TICK, 8'd150);
    send_run(KIND_TICK, 0, int'(RST_VERY_LOW_THRESHOLD) - 1, 258);
    send_run(KIND_EVENT, 0, 255, 1);
    send_item(KIND_TICK, 8'd40);
    send_item(KIND_TICK, 8'd90);
    send_item(KIND_TICK, 8'd110);
    send_item(KIND_TICK, 8'd120);
  endtask

  // Random settings, then runs of samples that dwell in one band at a time.
  task automatic test_random_traffic(input int n_items, input int send_pct,
                                     input int recv_pct);
    int        vl, sl, sp, st, ov, oh, lim, len, roll, goal, over_lo;
    logic      var_sel;
    run_kind_t run_kind;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    var_sel = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 3) == 0) begin
      // Unordered thresholds, so that the bands overlap.
      ov = $urandom_range(0, 255);
      oh = $urandom_range(0, 255);
      st = $urandom_range(0, 255);
      sp = $urandom_range(0, 255);
      vl = $urandom_range(0, 255);
      sl = $urandom_range(0, 255);
    end else begin
      vl = $urandom_range(20, 90);
      sl = vl + $urandom_range(0, 30);
      sp = sl + $urandom_range(0, 40);
      st = sp + $urandom_range(0, 20);
      ov = $urandom_range(st, 215);
      oh = $urandom_range(ov, 255);
    end
    case ($urandom_range(0, 9))
      0:       lim = 65533;
      1:       lim = $urandom_range(13, 300);
      default: lim = $urandom_range(1, 12);
    endcase
    load_settings(16'(var_sel), 16'(ov), 16'(oh), 16'(st), 16'(sp), 16'(vl), 16'(sl),
                  16'(lim));
    over_lo = (var_sel ? oh : ov) + 1;
    goal = items_sent + n_items;
    while (items_sent < goal) begin
      roll = $urandom_range(0, 9);
      run_kind = (roll < 2) ? SEG_OVER : (roll < 3) ? SEG_HOLD : (roll < 5) ? SEG_LOW :
                 (roll < 6) ? SEG_SLEEP : (roll < 7) ? SEG_HYST : (roll < 8) ? SEG_OPERATE :
                 (roll < 9) ? SEG_EVENT : SEG_NOISE;
      case (run_kind)
        SEG_OVER: begin
          len = $urandom_range(1, ((lim < 30) ? lim : 30) + 4);
          send_run(KIND_TICK, over_lo, 255, len);
        end
        SEG_HOLD:    send_run(KIND_TICK, int'(HOLD_BAND_LEVEL), oh, $urandom_range(1, 10));
        SEG_LOW: begin
          len = ($urandom_range(0, 29) == 0) ? 260 : $urandom_range(1, 30);
          send_run(KIND_TICK, 0, vl - 1, len);
        end
        SEG_SLEEP:   send_run(KIND_TICK, vl, sl - 1, $urandom_range(1, 6));
        SEG_HYST:    send_run(KIND_TICK, sp, st - 1, $urandom_range(1, 6));
        SEG_OPERATE: send_run(KIND_TICK, st, ov, $urandom_range(1, 8));
        SEG_EVENT:   send_run(KIND_EVENT, 0, 255, $urandom_range(1, 3));
        default: begin
          for (int i = $urandom_range(1, 5); i > 0; i--)
            send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        end
      endcase
    end
  endtask

  // Test sequence.
  initial begin
    rst           = 1'b1;
    sample_valid  = 1'b0;
    sample_bus    = '0;
    result_ready  = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_VARIANT_MODE;
    cfg_data      = '0;
    send_idle_pct = 6;
    recv_idle_pct = 80;
    reset_model();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_over_voltage_trip();
    test_alternate_hold_band();
    test_threshold_extremes();
    test_random_traffic(160, 6, 80);
    test_low_count_saturation(80, 6);
    test_random_traffic(160, 80, 6);
    test_random_traffic(160, 0, 0);

    drain_results();
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived, expected 0, actual %0d", $time,
               pending_results.size(), pending_results.size());
      mismatch_count++;
    end
    $display("Covered %0d sample transfers and %0d checked results over %0d register writes,",
             items_sent, results_checked, reg_writes);
    $display("spanning both variants, threshold extremes and low counter saturation.");
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/svs_pkg.sv
hdl/supply_voltage_supervisor.sv
tb/tb_supply_voltage_supervisor.sv
